// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/pag_pkg.sv
package pag_pkg;
  localparam int unsigned IdW = 15;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_WORD  = 1'b1
  } action_e;

  localparam logic CFG_EDGES  = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  // Control sent from the sequencer to every cell of the candidate row.
  typedef struct packed {
    logic            clear;   // drop all candidates
    logic            insert;  // insert id in sorted order
    logic [IdW-1:0]  id;
    logic            shift;   // advance the row by one toward the head
  } cell_ctrl_t;
endpackage

// File: src/pag_stream_if.sv
interface pag_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/pag_cell.sv
// One slot of the sorted candidate row. A cell holds one id and a valid bit.
// On insert, the insertion point takes the new id and later cells take the
// left neighbor's value; on shift, every cell takes its right neighbor's value.
module pag_cell
  import pag_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_ctrl_t     ctrl_i,
  input  logic           left_vld_i,
  input  logic [IdW-1:0] left_id_i,
  input  logic           left_gt_i,   // left neighbor holds a value above id
  input  logic           right_vld_i,
  input  logic [IdW-1:0] right_id_i,
  output logic           vld_o,
  output logic [IdW-1:0] id_o,
  output logic           gt_o,
  output logic           eq_o
);
  logic           vld_q;
  logic [IdW-1:0] id_q;

  assign vld_o = vld_q;
  assign id_o  = id_q;
  assign gt_o  = vld_q && (id_q > ctrl_i.id);
  assign eq_o  = vld_q && (id_q == ctrl_i.id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      id_q  <= '0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        vld_q <= left_vld_i;
        id_q  <= left_id_i;
      end else if (left_vld_i && (gt_o || !vld_q)) begin
        // take the new id only at the insertion point, not in every empty slot
        vld_q <= 1'b1;
        id_q  <= ctrl_i.id;
      end
    end else if (ctrl_i.shift) begin
      vld_q <= right_vld_i;
      id_q  <= right_id_i;
    end
  end
endmodule

// File: src/pag_row.sv
// Row of candidate cells. Reports a duplicate hit and the count of held ids;
// the head cell is read out while the row shifts.
module pag_row
  import pag_pkg::*;
#(
  parameter int unsigned N = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  output logic                   hit_o,
  output logic [$clog2(N+1)-1:0] count_o,
  output logic [IdW-1:0]         head_o
);
  logic [N-1:0]           vld, gt, eq;
  logic [N-1:0][IdW-1:0]  ids;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic           lv, lg, rv;
    logic [IdW-1:0] li, ri;
    if (g == 0) begin : g_first
      // head has no left neighbor: treat it as filled so an insert may land here
      assign lv = 1'b1;
      assign li = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = vld[g-1];
      assign li = ids[g-1];
      assign lg = gt[g-1];
    end
    if (g == N-1) begin : g_last
      assign rv = 1'b0;
      assign ri = '0;
    end else begin : g_next
      assign rv = vld[g+1];
      assign ri = ids[g+1];
    end
    pag_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i,
      .left_vld_i(lv), .left_id_i(li), .left_gt_i(lg),
      .right_vld_i(rv), .right_id_i(ri),
      .vld_o(vld[g]), .id_o(ids[g]), .gt_o(gt[g]), .eq_o(eq[g])
    );
  end

  assign hit_o  = |eq;
  assign head_o = ids[0];

  always_comb begin
    count_o = '0;
    for (int i = 0; i < N; i++) begin
      count_o = count_o + $bits(count_o)'(vld[i]);
    end
  end
endmodule

// File: src/preferential_attachment_graph_gen_top.sv
// Barabasi-Albert edge stream generator.
// Input channel in_if carries {random_word, action}: action START (0) begins
// a new graph, WORD (1) brings one random word. Output channel out_if carries
// {finished, last_edge, edge_target, edge_source}, one item per edge.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i, index 0 edges_per_node, 1 target_nodes;
// write only while idle.
// A word passes through the accepting cycle, a step to scale it into a list index
// (32x21 multiply), the choice memory read and the insert into the
// sorted candidate row of cells. When m distinct candidates are held the row
// shifts its head out once per cycle while the output register is free: each
// shift emits one edge and appends the target to the list, then the new node
// id is appended m times. Items are handled one at a time.
// The output register holds an edge while the receiver stalls; the sequencer
// waits on it. Reset clears all control state but not the choice memory, which
// is read every cycle; only entries below the list length, all written, are used.
module preferential_attachment_graph_gen_top
  import pag_pkg::*;
#(
  parameter int unsigned MAX_NODES          = 32768,
  parameter int unsigned MAX_EDGES_PER_NODE = 16,
  parameter int unsigned CHOICE_DEPTH       = 1048576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pag_stream_if.sink   in_if,
  pag_stream_if.source out_if,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  `include "assert_macros.svh"

  localparam int unsigned LW = $clog2(CHOICE_DEPTH + 1);
  localparam int unsigned AW = $clog2(CHOICE_DEPTH);
  localparam int unsigned CW = $clog2(MAX_EDGES_PER_NODE + 1);
  localparam int unsigned NW = 17;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_READ, S_INS, S_EMIT, S_APP
  } state_e;

  state_e          state_q;
  logic [4:0]      m_cfg_q;
  logic [15:0]     tgt_cfg_q;
  logic [LW-1:0]   len_q;
  logic [NW-1:0]   node_q;
  logic            done_q, started_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   m_q;
  logic [IdW-1:0]  src_q, rd_q;
  logic [AW-1:0]   pick_q;
  logic [IdW-1:0]  mem [CHOICE_DEPTH];
  logic            ov_q;
  logic [IdW-1:0]  os_q, ot_q;
  logic            ol_q, of_q;
  logic [IdW-1:0]  seed_q;

  cell_ctrl_t                ctrl;
  logic                      hit;
  logic [$clog2(MAX_EDGES_PER_NODE+1)-1:0] ccnt;
  logic [IdW-1:0]            head;

  logic [CW-1:0]  m_eff;
  logic [NW-1:0]  tgt_eff;
  logic           act;
  logic [31:0]    word;

  assign act  = in_if.data[0];
  assign word = in_if.data[32:1];

  always_comb begin
    if (m_cfg_q == 5'd0) m_eff = CW'(1);
    else if (32'(m_cfg_q) > MAX_EDGES_PER_NODE) m_eff = CW'(MAX_EDGES_PER_NODE);
    else m_eff = CW'(m_cfg_q);
    if (32'(tgt_cfg_q) > MAX_NODES) tgt_eff = NW'(MAX_NODES);
    else tgt_eff = NW'(tgt_cfg_q);
  end

  logic [31:0]    word_q;
  logic           out_free;
  logic           app_we;
  logic [IdW-1:0] app_id;

  assign out_free     = !ov_q || out_if.ready;
  assign in_if.ready  = (state_q == S_IDLE);
  assign out_if.valid = ov_q;
  assign out_if.data  = {of_q, ol_q, ot_q, os_q};

  // Leftover candidates beyond m must be cleared after completion.
  // Handled by pag_row clear on the cycle leaving S_APP.
  logic clr_tail;
  assign clr_tail = (state_q == S_APP) && ((cnt_q + CW'(1)) == m_q);

  always_comb begin
    ctrl        = '0;
    ctrl.id     = rd_q;
    ctrl.clear  = ((state_q == S_IDLE) && in_if.valid && (act == ACT_START)) || clr_tail;
    ctrl.insert = (state_q == S_INS) && !hit &&
                  (32'(ccnt) < MAX_EDGES_PER_NODE);
    ctrl.shift  = (state_q == S_EMIT) && started_q && out_free && seed_q == '1;
  end

  pag_row #(.N(MAX_EDGES_PER_NODE)) u_row (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .hit_o(hit), .count_o(ccnt), .head_o(head)
  );

  // seed_q == all ones means targets come from the row, otherwise a counter
  logic [IdW-1:0] tgt_id;
  assign tgt_id = (seed_q == '1) ? head : seed_q;
  assign app_we = ((state_q == S_EMIT) && out_free) || (state_q == S_APP);
  assign app_id = (state_q == S_APP) ? src_q : tgt_id;

  always_ff @(posedge clk_i) begin
    if (app_we && len_q < LW'(CHOICE_DEPTH)) mem[AW'(len_q)] <= app_id;
    rd_q <= mem[pick_q];
  end

  logic [63:0] prod;
  assign prod = 64'(word_q) * 64'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_cfg_q   <= 5'd7;
      tgt_cfg_q <= 16'd30000;
      len_q     <= '0;
      node_q    <= '0;
      done_q    <= 1'b0;
      started_q <= 1'b0;
      cnt_q     <= '0;
      m_q       <= '0;
      seed_q    <= '1;
      ov_q      <= 1'b0;
      src_q     <= '0;
      pick_q    <= '0;
      word_q    <= '0;
      os_q <= '0; ot_q <= '0; ol_q <= 1'b0; of_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_EDGES) m_cfg_q <= cfg_data_i[4:0];
        else tgt_cfg_q <= cfg_data_i;
      end
      if (ov_q && out_if.ready && state_q != S_EMIT) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            if (act == ACT_START) begin
              len_q     <= '0;
              m_q       <= m_eff;
              if (NW'(m_eff) >= tgt_eff) begin
                node_q <= NW'(m_eff);
                done_q <= 1'b1;
              end else begin
                started_q <= 1'b1;
                seed_q    <= '0;
                cnt_q     <= '0;
                src_q     <= IdW'(m_eff);
                node_q    <= NW'(m_eff) + NW'(1);
                done_q    <= (NW'(m_eff) + NW'(1)) >= tgt_eff;
                state_q   <= S_EMIT;
              end
            end else if (node_q != '0 && !done_q && len_q != '0) begin
              if (node_q >= tgt_eff) done_q <= 1'b1;
              else begin
                word_q  <= word;
                state_q <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          pick_q  <= AW'(prod[63:32]);
          state_q <= S_READ;
        end
        S_READ: state_q <= S_INS;
        S_INS: begin
          // count after insertion is ccnt + insert
          if (32'(ccnt) + 32'(ctrl.insert) >= 32'(m_eff)) begin
            m_q     <= m_eff;
            cnt_q   <= '0;
            seed_q  <= '1;
            src_q   <= IdW'(node_q);
            node_q  <= node_q + NW'(1);
            done_q  <= (node_q + NW'(1)) >= tgt_eff;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            os_q <= src_q;
            ot_q <= tgt_id;
            ol_q <= (cnt_q + CW'(1)) == m_q;
            of_q <= done_q;
            if (len_q < LW'(CHOICE_DEPTH)) len_q <= len_q + LW'(1);
            if (seed_q != '1) seed_q <= seed_q + IdW'(1);
            if ((cnt_q + CW'(1)) == m_q) begin
              cnt_q   <= '0;
              state_q <= S_APP;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        S_APP: begin
          if (len_q < LW'(CHOICE_DEPTH)) len_q <= len_q + LW'(1);
          if ((cnt_q + CW'(1)) == m_q) begin
            seed_q  <= '1;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_in_idle, clk_i, rst_ni, in_if.ready, state_q == S_IDLE)
  `ASSERT_IMPL(a_len_max, clk_i, rst_ni, 1'b1, len_q <= LW'(CHOICE_DEPTH))
  `ASSERT_NEXT(a_app_end, clk_i, rst_ni, clr_tail, state_q == S_IDLE)
endmodule

// File: tb/preferential_attachment_graph_gen_top_tb.sv
module preferential_attachment_graph_gen_top_tb;
  import pag_pkg::*;

  localparam int unsigned MaxNodes = 32768;
  localparam int unsigned MaxM     = 16;
  localparam int unsigned Depth    = 1048576;
  localparam int unsigned NumItems = 410;
  // settle time after the last edge: a word that completes nothing may still be in flight
  localparam int unsigned SettleCycles = 3 + 2 * MaxM + 8;

  typedef struct packed {
    logic           finished;
    logic           last_edge;
    logic [IdW-1:0] edge_target;
    logic [IdW-1:0] edge_source;
  } edge_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        idx;
    logic [15:0] data;
    action_e     act;
    logic [31:0] word;
    bit          typed;
    edge_t       first_edge;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  pag_stream_if #(.W(33)) req_if ();
  pag_stream_if #(.W(32)) edge_if ();

  preferential_attachment_graph_gen_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (req_if),
    .out_if    (edge_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // graph model state
  logic [IdW-1:0] choice_q[$];
  logic [IdW-1:0] cand_ids[MaxM];
  logic [IdW-1:0] target_ids[MaxM];
  int unsigned    cand_n;
  int unsigned    node_n;
  bit             gen_done;
  logic [4:0]     m_reg;
  logic [15:0]    target_reg;

  edge_t       edges_q[$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          calm;
  bit          hold_req;
  row_t        rows[$];

  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  function automatic int unsigned eff_m();
    if (m_reg == 0) return 1;
    if (m_reg > MaxM) return MaxM;
    return m_reg;
  endfunction

  function automatic int unsigned eff_target();
    return (target_reg > MaxNodes) ? MaxNodes : target_reg;
  endfunction

  function automatic void append_choice(input logic [IdW-1:0] id);
    if (choice_q.size() < Depth) choice_q.push_back(id);
  endfunction

  function automatic void add_node(input int unsigned m);
    logic [IdW-1:0] src;
    edge_t          e;
    src = node_n[IdW-1:0];
    node_n++;
    if (node_n >= eff_target()) gen_done = 1'b1;
    for (int unsigned i = 0; i < m; i++) begin
      e.edge_source = src;
      e.edge_target = target_ids[i];
      e.last_edge   = (i + 1 == m);
      e.finished    = gen_done;
      edges_q.push_back(e);
    end
    for (int unsigned i = 0; i < m; i++) append_choice(target_ids[i]);
    for (int unsigned i = 0; i < m; i++) append_choice(src);
  endfunction

  function automatic void predict_graph(input action_e act, input logic [31:0] word);
    int unsigned    m;
    int unsigned    j;
    logic [63:0]    prod;
    logic [IdW-1:0] id;
    bit             seen;
    m = eff_m();
    if (act == ACT_START) begin
      choice_q.delete();
      cand_n   = 0;
      gen_done = 1'b0;
      for (int unsigned i = 0; i < m; i++) target_ids[i] = i[IdW-1:0];
      node_n = m;
      if (node_n >= eff_target()) begin
        gen_done = 1'b1;
        return;
      end
      add_node(m);
      return;
    end
    if (node_n == 0 || gen_done || choice_q.size() == 0) return;
    if (node_n >= eff_target()) begin
      gen_done = 1'b1;
      return;
    end
    prod = {32'd0, word} * 64'(choice_q.size());
    id   = choice_q[prod[63:32]];
    seen = 1'b0;
    for (int unsigned i = 0; i < cand_n; i++) if (cand_ids[i] == id) seen = 1'b1;
    if (!seen && cand_n < MaxM) begin
      j = cand_n;
      while (j > 0 && cand_ids[j-1] > id) begin
        cand_ids[j] = cand_ids[j-1];
        j--;
      end
      cand_ids[j] = id;
      cand_n++;
    end
    if (cand_n < m) return;
    for (int unsigned i = 0; i < m; i++) target_ids[i] = cand_ids[i];
    cand_n = 0;
    add_node(m);
  endfunction

  task automatic send_request(input action_e act, input logic [31:0] word, output int first);
    if (!calm && $urandom_range(99) < 30) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= {word, act};
    do @(posedge clk_i); while (!req_if.ready);
    first = edges_q.size();
    predict_graph(act, word);
    items_sent++;
  endtask

  // drop valid, wait out every pending edge, then let the block settle
  task automatic drain();
    req_if.valid <= 1'b0;
    while (edges_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_EDGES) m_reg = data[4:0];
    else target_reg = data;
    @(posedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin : edge_sink
    int unsigned hold_cnt;
    edge_t       got;
    edge_t       want;
    if (edge_if.valid && edge_if.ready) begin
      got = edge_if.data;
      if (edges_q.size() == 0) begin
        report($sformatf("unexpected edge %0d->%0d", got.edge_source, got.edge_target));
      end else begin
        want = edges_q.pop_front();
        if (got.edge_source !== want.edge_source)
          report($sformatf("edge_source %0d, want %0d", got.edge_source, want.edge_source));
        if (got.edge_target !== want.edge_target)
          report($sformatf("edge_target %0d, want %0d", got.edge_target, want.edge_target));
        if (got.last_edge !== want.last_edge)
          report($sformatf("last_edge %0b, want %0b", got.last_edge, want.last_edge));
        if (got.finished !== want.finished)
          report($sformatf("finished %0b, want %0b", got.finished, want.finished));
      end
    end
    if (hold_req && hold_cnt == 0) hold_cnt = 300;
    if (hold_cnt != 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_req = 1'b0;
      edge_if.ready <= 1'b0;
    end else begin
      edge_if.ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  initial begin
    #5_000_000;
    $display("preferential_attachment_graph_gen_top_tb NOT OK");
    $finish;
  end

  initial begin : stim
    int          first;
    int unsigned m;
    int unsigned words;
    int unsigned phase;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_EDGES;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    edge_if.ready = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    items_sent = 0;
    choice_q.delete();
    cand_n     = 0;
    node_n     = 0;
    gen_done   = 1'b0;
    m_reg      = 5'd7;
    target_reg = 16'd30000;
    for (int i = 0; i < MaxM; i++) begin
      cand_ids[i]   = '0;
      target_ids[i] = '0;
    end

    // word before start, reset settings, then each corner of the two registers
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'd5, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b1,
                     '{1'b0, 1'b0, 15'd0, 15'd7}});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h0000_0000, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h5555_5555, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hAAAA_AAAA, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd1, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'd2, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b1,
                     '{1'b1, 1'b1, 15'd0, 15'd1}});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'd3, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b1,
                     '{1'b0, 1'b1, 15'd0, 15'd1}});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'd0, 1'b1,
                     '{1'b1, 1'b1, 15'd0, 15'd2}});
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd31, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'd16, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h1234_5678, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'hFFFF, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b1,
                     '{1'b0, 1'b0, 15'd0, 15'd16}});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd3, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'd100, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h0000_0001, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hFFFF_FFFE, 1'b0, '0});
    // raise m past the distinct nodes in the list: nothing completes
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd16, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h0000_0000, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hC000_0000, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'hFFFF_FFFF, 1'b0, '0});
    // lower m: the lowest candidates win
    rows.push_back('{ROW_CFG, CFG_EDGES, 16'd2, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'h7FFF_FFFF, 1'b0, '0});
    // lower the target under the node count
    rows.push_back('{ROW_CFG, CFG_TARGET, 16'd2, ACT_START, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'd0, 1'b0, '0});
    rows.push_back('{ROW_ITEM, CFG_EDGES, 16'd0, ACT_WORD, 32'd9, 1'b0, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) begin
        drain();
        write_reg(rows[r].idx, rows[r].data);
      end else begin
        send_request(rows[r].act, rows[r].word, first);
        if (rows[r].typed) begin
          if (edges_q.size() <= first) report("directed row produced no edge");
          else edges_q[first] = rows[r].first_edge;
        end
      end
    end

    phase = 0;
    while (items_sent < NumItems) begin
      drain();
      case ($urandom_range(9))
        0: m = $urandom_range(17, 31);
        1: m = 0;
        default: m = $urandom_range(1, MaxM);
      endcase
      write_reg(CFG_EDGES, 16'(m));
      case ($urandom_range(9))
        0: write_reg(CFG_TARGET, 16'($urandom_range(0, eff_m())));
        1, 2: write_reg(CFG_TARGET, 16'($urandom_range(MaxNodes, 65535)));
        default: write_reg(CFG_TARGET, 16'($urandom_range(eff_m() + 2, eff_m() + 40)));
      endcase
      calm     = (phase == 4 || phase == 5);
      hold_req = (phase == 2);
      send_request(ACT_START, $urandom, first);
      words = $urandom_range(10, 40);
      repeat (words) begin
        if ($urandom_range(99) < 4) send_request(ACT_START, $urandom, first);
        else send_request(ACT_WORD, $urandom, first);
      end
      phase++;
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("preferential_attachment_graph_gen_top_tb OK");
    end else begin
      $display("preferential_attachment_graph_gen_top_tb NOT OK");
    end
    $finish;
  end

endmodule
